// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/drig_pkg.sv =====
// constants and widths for the distinct random index generator
// no dependencies
package drig_pkg;

	localparam int MAX_INDEX_BITS = 9;
	localparam int MAX_COUNT      = 32;
	localparam int MAP_DEPTH      = 1 << MAX_INDEX_BITS;
	localparam int CW             = $clog2(MAX_COUNT + 1);
	localparam int EPOCH_W        = 8;

	localparam logic [31:0] LCG_MUL  = 32'd1103515245;
	localparam logic [31:0] LCG_ADD  = 32'd12345;
	localparam logic [31:0] LCG_MASK = 32'h7fffffff;

	localparam int SEED_W  = 32;
	localparam int OWNER_W = 2;
	localparam int PICK_W  = 9;
	localparam int POS_W   = 6;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 24;

	localparam int IB_W  = 4;
	localparam int CNT_W = 6;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [ADDR_W-1:0] ADDR_INDEX_BITS  = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] ADDR_COUNT       = ADDR_W'(4);
	localparam logic [ADDR_W-1:0] ADDR_RESERVE     = ADDR_W'(8);

	localparam logic [IB_W-1:0]  RST_INDEX_BITS = IB_W'(9);
	localparam logic [CNT_W-1:0] RST_COUNT      = CNT_W'(31);
	localparam logic             RST_RESERVE    = 1'b1;

endpackage

// ===== rtl/distinct_random_index_generator_top.sv =====
// distinct random index generator, top level
// depends on drig_pkg and assert_macros.svh
//
// usage:
//   s_* takes one seed beat: tdata holds seed and owner_tag. For each seed the block
//   draws count_wanted distinct indices (clamped to the usable indices and to 32) from a
//   linear congruential generator reduced to 2^index_bits, and returns one m_* beat
//   per index with its table position and the owner tag; tlast marks the final one.
//   A count of zero returns no beats.
//   s_tready is high only while no run is in progress. Each generator step first
//   computes the next value and reads the map, then checks it and emits; the check
//   holds while the output register is full and m_tready is low.
//   The used map is a 512 x 8 memory tagged with a run number. After reset, and
//   before every 255th seed when the run number wraps, a clearing pass writes all
//   512 entries of the map while s_tready stays low.
//   Results sit in an output register; when m_tready is low the generator holds
//   until the register is free and no beat is lost.
//   The apb port writes index_bits (0x0), count_wanted (0x4) and reserve_zero (0x8);
//   the user must write them only while the block is idle, which the block does not enforce.
//   pready is always high. arst_n clears all control state and loads the register reset values 9, 31 and 1.
module distinct_random_index_generator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [drig_pkg::IN_W-1:0]     s_tdata,   // seed[31:0], owner_tag[33:32], zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [drig_pkg::OUT_W-1:0]    m_tdata,   // picked_index[8:0], table_position[14:9],
	                                                 // owner_echo[16:15], zero pad
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [drig_pkg::ADDR_W-1:0]   paddr,
	input  logic [drig_pkg::DATA_W-1:0]   pwdata,
	output logic [drig_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int IW = drig_pkg::MAX_INDEX_BITS;
	localparam int CW = drig_pkg::CW;
	localparam int EW = drig_pkg::EPOCH_W;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STEP,
		ST_CHECK
	} state_t;

	state_t state_q;

	logic [drig_pkg::IB_W-1:0]  index_bits_q;
	logic [drig_pkg::CNT_W-1:0] count_wanted_q;
	logic                       reserve_q;

	logic [IW-1:0]  gen_q;
	logic [IW-1:0]  cur_q;
	logic [IW-1:0]  mask_q;
	logic [IW:0]    steps_q;
	logic [IW:0]    limit_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  emitted_q;
	logic           run_reserve_q;
	logic [drig_pkg::OWNER_W-1:0] owner_q;
	logic [EW-1:0]  epoch_q;
	logic [IW-1:0]  clr_q;

	logic [drig_pkg::PICK_W-1:0]  pick_q;
	logic [drig_pkg::POS_W-1:0]   pos_q;
	logic [drig_pkg::OWNER_W-1:0] owner_out_q;
	logic                         last_q;
	logic                         m_valid_q;

	logic [EW-1:0] map_mem [drig_pkg::MAP_DEPTH];
	logic [EW-1:0] rd_q;

	// configuration
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q   <= drig_pkg::RST_INDEX_BITS;
			count_wanted_q <= drig_pkg::RST_COUNT;
			reserve_q      <= drig_pkg::RST_RESERVE;
		end else if (cfg_wr) begin
			unique case (paddr)
				drig_pkg::ADDR_INDEX_BITS: index_bits_q   <= pwdata[drig_pkg::IB_W-1:0];
				drig_pkg::ADDR_COUNT:      count_wanted_q <= pwdata[drig_pkg::CNT_W-1:0];
				drig_pkg::ADDR_RESERVE:    reserve_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			drig_pkg::ADDR_INDEX_BITS: prdata = drig_pkg::DATA_W'(index_bits_q);
			drig_pkg::ADDR_COUNT:      prdata = drig_pkg::DATA_W'(count_wanted_q);
			drig_pkg::ADDR_RESERVE:    prdata = drig_pkg::DATA_W'(reserve_q);
			default:                   prdata = '0;
		endcase
	end

	// run setup
	logic [drig_pkg::IB_W-1:0] bits_n;
	logic [IW:0]   range_n;
	logic [IW:0]   avail_n;
	logic [15:0]   cnt16_n;
	logic [CW-1:0] count_n;

	always_comb begin
		if (index_bits_q == '0)
			bits_n = drig_pkg::IB_W'(1);
		else if (index_bits_q > drig_pkg::IB_W'(IW))
			bits_n = drig_pkg::IB_W'(IW);
		else
			bits_n = index_bits_q;
		range_n = (IW+1)'(1) << bits_n;
		avail_n = range_n - (IW+1)'(reserve_q);
		cnt16_n = 16'(count_wanted_q);
		if (cnt16_n > 16'(avail_n))
			cnt16_n = 16'(avail_n);
		if (cnt16_n > 16'(drig_pkg::MAX_COUNT))
			cnt16_n = 16'(drig_pkg::MAX_COUNT);
		count_n = CW'(cnt16_n);
	end

	// shared generator step
	logic [2*IW-1:0] prod;
	logic [IW-1:0]   cur_n;
	assign prod  = {{IW{1'b0}}, gen_q} * {{IW{1'b0}}, drig_pkg::LCG_MUL[IW-1:0]};
	assign cur_n = (prod[IW-1:0] + drig_pkg::LCG_ADD[IW-1:0])
		& drig_pkg::LCG_MASK[IW-1:0] & mask_q;

	logic seed_acc;
	logic used;
	logic can_load;
	logic emit;
	logic done_emit;
	logic bound_hit;

	assign s_tready  = (state_q == ST_IDLE);
	assign seed_acc  = s_tvalid && s_tready;
	assign used      = (rd_q == epoch_q) || (run_reserve_q && cur_q == '0);
	assign can_load  = !m_valid_q || m_tready;
	assign emit      = (state_q == ST_CHECK) && !used && can_load;
	assign done_emit = (emitted_q + CW'(1)) == count_q;
	assign bound_hit = steps_q == limit_q;

	// used map
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	assign mem_we    = (state_q == ST_CLEAR) || emit;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : cur_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : epoch_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			map_mem[mem_waddr] <= mem_wdata;
		if (state_q == ST_STEP)
			rd_q <= map_mem[cur_n];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			epoch_q       <= EW'(1);
			clr_q         <= '0;
			count_q       <= '0;
			emitted_q     <= '0;
			steps_q       <= '0;
			limit_q       <= '0;
			mask_q        <= '0;
			gen_q         <= '0;
			cur_q         <= '0;
			run_reserve_q <= 1'b0;
			owner_q       <= '0;
			m_valid_q     <= 1'b0;
			last_q        <= 1'b0;
			pick_q        <= '0;
			pos_q         <= '0;
			owner_out_q   <= '0;
		end else begin
			if (emit)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == '1)
						state_q <= (count_q != '0) ? ST_STEP : ST_IDLE;
				end
				ST_IDLE: begin
					if (seed_acc) begin
						gen_q         <= s_tdata[IW-1:0];
						owner_q       <= s_tdata[drig_pkg::SEED_W +: drig_pkg::OWNER_W];
						mask_q        <= IW'(range_n - (IW+1)'(1));
						limit_q       <= range_n + (IW+1)'(1);
						count_q       <= count_n;
						run_reserve_q <= reserve_q;
						emitted_q     <= '0;
						steps_q       <= '0;
						if (epoch_q == '1) begin
							// run number wraps: wipe the map first
							epoch_q <= EW'(1);
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							epoch_q <= epoch_q + EW'(1);
							state_q <= (count_n != '0) ? ST_STEP : ST_IDLE;
						end
					end
				end
				ST_STEP: begin
					cur_q   <= cur_n;
					gen_q   <= cur_n;
					steps_q <= steps_q + (IW+1)'(1);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (used) begin
						state_q <= bound_hit ? ST_IDLE : ST_STEP;
					end else if (can_load) begin
						pick_q      <= drig_pkg::PICK_W'(cur_q);
						pos_q       <= drig_pkg::POS_W'(emitted_q)
							+ drig_pkg::POS_W'(run_reserve_q);
						owner_out_q <= owner_q;
						last_q      <= done_emit || bound_hit;
						emitted_q   <= emitted_q + CW'(1);
						state_q     <= (done_emit || bound_hit) ? ST_IDLE : ST_STEP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {
		(drig_pkg::OUT_W - drig_pkg::PICK_W - drig_pkg::POS_W - drig_pkg::OWNER_W)'(0),
		owner_out_q, pos_q, pick_q};

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_emit_bound, clk, arst_n, emitted_q <= count_q)
	`ASSERT_NEXT(a_last_ends_run, clk, arst_n, emit && done_emit, s_tready)
	`ASSERT_ALWAYS(a_no_emit_in_clear, clk, arst_n, !(state_q == ST_CLEAR && $rose(m_tvalid)))
	`ASSERT_ALWAYS(a_epoch_nonzero, clk, arst_n, epoch_q != '0)

endmodule
